@@ hw/rtl/voxel_face_culler_defines.svh @@
// ----------------------------------------------------------------------------
// Voxel face culler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULLER_DEFINES_SVH
`define VOXEL_FACE_CULLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VFC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VFC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/vfc_pkg.sv @@
// ----------------------------------------------------------------------------
// vfc_pkg
// Types, grid constants and the texture table of the voxel face culler.
// ----------------------------------------------------------------------------
`default_nettype none

package vfc_pkg;

  localparam int SIDE      = 32;
  localparam int HEIGHT    = 64;
  localparam int DEPTH     = SIDE * SIDE * HEIGHT;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam int X_W       = 5;
  localparam int Y_W       = 6;
  localparam int Z_W       = 5;
  localparam int KIND_W    = 8;
  localparam int TEX_W     = 4;
  localparam int FACE_W    = 3;
  localparam int NUM_FACES = 6;
  localparam int NUM_KINDS = 10;
  localparam int KIND_IDX_W = $clog2(NUM_KINDS);
  localparam int STEP_W    = 3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd1;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd2;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd4;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd5;

  localparam logic [TEX_W-1:0] TEX_TABLE [NUM_KINDS][NUM_FACES] = '{
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd1, 4'd1, 4'd0, 4'd1, 4'd2, 4'd1},
    '{4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3},
    '{4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2},
    '{4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4},
    '{4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5},
    '{4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6},
    '{4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7},
    '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
    '{4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9}
  };

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EMIT
  } vfc_state_t;

  typedef struct packed {
    logic              req_type;
    logic [X_W-1:0]    pos_x;
    logic [Y_W-1:0]    pos_y;
    logic [Z_W-1:0]    pos_z;
    logic [KIND_W-1:0] write_type;
  } vfc_in_t;

  typedef struct packed {
    logic              face_valid;
    logic [FACE_W-1:0] face_id;
    logic [X_W-1:0]    out_x;
    logic [Y_W-1:0]    out_y;
    logic [Z_W-1:0]    out_z;
    logic [KIND_W-1:0] block_kind;
    logic [TEX_W-1:0]  texture_layer;
    logic              last;
  } vfc_out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [KIND_W-1:0] wdata;
  } mem_req_t;

  // Unlisted block types use layer zero on every face.
  function automatic logic [TEX_W-1:0] texture_of(input logic [KIND_W-1:0] kind,
                                                  input logic [FACE_W-1:0] face);
    if (kind >= KIND_W'(NUM_KINDS) || face >= FACE_W'(NUM_FACES)) begin
      return '0;
    end
    return TEX_TABLE[kind[KIND_IDX_W-1:0]][face];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vfc_ram.sv @@
// ----------------------------------------------------------------------------
// vfc_ram
// Generic single-port synchronous RAM, read-first, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/vfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// vfc_ctrl
// Sequencer: clearing pass, voxel writes, neighbour reads and face emission.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_face_culler_defines.svh"

module vfc_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire vfc_pkg::vfc_in_t              in_item,
  output logic                               busy,
  input  wire logic                          cull_en,
  output vfc_pkg::mem_req_t                  mem_req,
  input  wire logic [vfc_pkg::KIND_W-1:0]    mem_rdata,
  output logic                               out_strobe,
  output vfc_pkg::vfc_out_t                  out_item
);

  vfc_pkg::vfc_state_t state_r, state_nxt;

  logic [vfc_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [vfc_pkg::X_W-1:0]       x_r, x_nxt;
  logic [vfc_pkg::Y_W-1:0]       y_r, y_nxt;
  logic [vfc_pkg::Z_W-1:0]       z_r, z_nxt;
  logic                          center_ok_r, center_ok_nxt;
  logic [vfc_pkg::KIND_W-1:0]    kind_r, kind_nxt;
  logic [vfc_pkg::NUM_FACES-1:0] mask_r, mask_nxt;
  logic [vfc_pkg::ADDR_W-1:0]    clr_addr_r, clr_addr_nxt;
  logic                          out_valid_r, out_valid_nxt;
  vfc_pkg::vfc_out_t             out_item_r, out_item_nxt;

  logic                          accept;
  logic                          in_ok;
  logic [vfc_pkg::NUM_FACES-1:0] nb_ok;
  logic [vfc_pkg::ADDR_W-1:0]    step_addr;
  logic [vfc_pkg::FACE_W-1:0]    data_face;
  logic [vfc_pkg::FACE_W-1:0]    sel;
  logic [vfc_pkg::NUM_FACES-1:0] mask_left;
  logic [vfc_pkg::KIND_W-1:0]    center_kind;

  function automatic logic [vfc_pkg::ADDR_W-1:0] cell_addr(
      input logic [vfc_pkg::X_W:0] x,
      input logic [vfc_pkg::Y_W:0] y,
      input logic [vfc_pkg::Z_W:0] z);
    return vfc_pkg::ADDR_W'(x) + vfc_pkg::ADDR_W'(vfc_pkg::SIDE) *
           (vfc_pkg::ADDR_W'(z) + vfc_pkg::ADDR_W'(vfc_pkg::SIDE) * vfc_pkg::ADDR_W'(y));
  endfunction

  assign accept = start && (state_r == vfc_pkg::S_IDLE);

  assign in_ok = (32'(in_item.pos_x) < vfc_pkg::SIDE) &&
                 (32'(in_item.pos_y) < vfc_pkg::HEIGHT) &&
                 (32'(in_item.pos_z) < vfc_pkg::SIDE);

  // The voxel itself is in the grid whenever these are used, so a step down
  // only leaves the grid at coordinate zero.
  assign nb_ok[vfc_pkg::FACE_FRONT]  = 32'(z_r) < vfc_pkg::SIDE - 1;
  assign nb_ok[vfc_pkg::FACE_RIGHT]  = 32'(x_r) < vfc_pkg::SIDE - 1;
  assign nb_ok[vfc_pkg::FACE_TOP]    = 32'(y_r) < vfc_pkg::HEIGHT - 1;
  assign nb_ok[vfc_pkg::FACE_LEFT]   = x_r != '0;
  assign nb_ok[vfc_pkg::FACE_BOTTOM] = y_r != '0;
  assign nb_ok[vfc_pkg::FACE_BACK]   = z_r != '0;

  // Read step zero is the voxel, steps one to six its neighbours in face order.
  always_comb begin
    logic [vfc_pkg::X_W:0] xw;
    logic [vfc_pkg::Y_W:0] yw;
    logic [vfc_pkg::Z_W:0] zw;
    xw = {1'b0, x_r};
    yw = {1'b0, y_r};
    zw = {1'b0, z_r};
    unique case (cnt_r)
      3'd1:    step_addr = cell_addr(xw, yw, zw + 1'b1);
      3'd2:    step_addr = cell_addr(xw + 1'b1, yw, zw);
      3'd3:    step_addr = cell_addr(xw, yw + 1'b1, zw);
      3'd4:    step_addr = cell_addr(xw - 1'b1, yw, zw);
      3'd5:    step_addr = cell_addr(xw, yw - 1'b1, zw);
      3'd6:    step_addr = cell_addr(xw, yw, zw - 1'b1);
      default: step_addr = cell_addr(xw, yw, zw);
    endcase
  end

  // Data returning at count k belongs to the read issued at count k-1.
  assign data_face   = vfc_pkg::FACE_W'(cnt_r - 3'd2);
  assign center_kind = center_ok_r ? mem_rdata : '0;

  always_comb begin
    sel = '0;
    for (int i = vfc_pkg::NUM_FACES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = vfc_pkg::FACE_W'(i);
      end
    end
  end

  assign mask_left = mask_r & ~(vfc_pkg::NUM_FACES'(1) << sel);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vfc_pkg::S_CLEAR: begin
        if (clr_addr_r == vfc_pkg::ADDR_W'(vfc_pkg::DEPTH - 1)) begin
          state_nxt = vfc_pkg::S_IDLE;
        end
      end
      vfc_pkg::S_IDLE: begin
        if (accept && in_item.req_type == vfc_pkg::REQ_QUERY) begin
          state_nxt = vfc_pkg::S_READ;
        end
      end
      vfc_pkg::S_READ: begin
        if (cnt_r == 3'd1 && (center_kind == '0 || !cull_en)) begin
          state_nxt = vfc_pkg::S_EMIT;
        end else if (cnt_r == 3'd7) begin
          state_nxt = vfc_pkg::S_EMIT;
        end
      end
      vfc_pkg::S_EMIT: begin
        if (mask_left == '0) begin
          state_nxt = vfc_pkg::S_IDLE;
        end
      end
      default: state_nxt = vfc_pkg::S_IDLE;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = step_addr;
    mem_req.wdata = in_item.write_type;
    busy          = 1'b1;
    unique case (state_r)
      vfc_pkg::S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_addr_r;
        mem_req.wdata = '0;
      end
      vfc_pkg::S_IDLE: begin
        busy         = 1'b0;
        mem_req.we   = accept && in_item.req_type == vfc_pkg::REQ_WRITE && in_ok;
        mem_req.addr = cell_addr({1'b0, in_item.pos_x}, {1'b0, in_item.pos_y},
                                 {1'b0, in_item.pos_z});
      end
      vfc_pkg::S_READ, vfc_pkg::S_EMIT: begin
        mem_req.we = 1'b0;
      end
      default: busy = 1'b1;
    endcase
  end

  // Datapath registers.
  always_comb begin
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    center_ok_nxt = center_ok_r;
    kind_nxt      = kind_r;
    mask_nxt      = mask_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      vfc_pkg::S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      vfc_pkg::S_IDLE: begin
        if (accept) begin
          x_nxt         = in_item.pos_x;
          y_nxt         = in_item.pos_y;
          z_nxt         = in_item.pos_z;
          center_ok_nxt = in_ok;
          cnt_nxt       = '0;
          mask_nxt      = '0;
        end
      end
      vfc_pkg::S_READ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 3'd1) begin
          kind_nxt = center_kind;
          if (center_kind != '0 && !cull_en) begin
            mask_nxt = '1;
          end
        end else if (cnt_r >= 3'd2) begin
          mask_nxt = mask_r | (vfc_pkg::NUM_FACES'(nb_ok[data_face] && mem_rdata == '0)
                               << data_face);
        end
      end
      vfc_pkg::S_EMIT: begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.face_valid    = mask_r != '0;
        out_item_nxt.face_id       = (mask_r != '0) ? sel : vfc_pkg::FACE_FRONT;
        out_item_nxt.out_x         = x_r;
        out_item_nxt.out_y         = y_r;
        out_item_nxt.out_z         = z_r;
        out_item_nxt.block_kind    = kind_r;
        out_item_nxt.texture_layer = (mask_r != '0) ? vfc_pkg::texture_of(kind_r, sel) : '0;
        out_item_nxt.last          = mask_left == '0;
        mask_nxt                   = mask_left;
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vfc_pkg::S_CLEAR;
      cnt_r       <= '0;
      mask_r      <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mask_r      <= mask_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
    center_ok_r <= center_ok_nxt;
    kind_r      <= kind_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;

  `VFC_ASSERT_NEXT(a_last_closes_query, out_valid_r && out_item_r.last, !out_valid_r, "result follows last of a query")
  `VFC_ASSERT_NOW(a_no_write_in_query, state_r == vfc_pkg::S_READ || state_r == vfc_pkg::S_EMIT, !mem_req.we, "store written during a query")
  `VFC_ASSERT_NOW(a_empty_is_last, out_valid_r && !out_item_r.face_valid, out_item_r.last, "faceless result not marked last")
  `VFC_ASSERT_NEXT(a_one_face_per_cycle, state_r == vfc_pkg::S_EMIT && mask_r != '0, $countones(mask_r) == $countones($past(mask_r)) - 1, "face mask did not drop one face")

endmodule

`default_nettype wire

@@ hw/rtl/voxel_face_culler.sv @@
// Writes complete in the cycle they are accepted and may follow back to back. A query
// keeps busy high while the store reads the voxel and, with culling on for a solid
// voxel, all six neighbours, and while its n results (1 to 6) are emitted; the one-port
// store, one read per cycle, sets this. Results of a query are registered out of S_EMIT.
// After reset busy stays high while all SIDE*SIDE*HEIGHT (65536) cells of the store
// are cleared to air. The receiver cannot stall; each result strobes one cycle.
// ----------------------------------------------------------------------------
// voxel_face_culler
// Visible-face finder for one chunk of a voxel grid held in on-chip RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_face_culler (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire vfc_pkg::vfc_in_t  in_item,
  output logic                   out_strobe,
  output vfc_pkg::vfc_out_t      out_item,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);

  // The culling switch. Writes are to be issued only while the block is idle; the
  // block itself does not enforce this, and the register is always open for them.
  logic cull_en_r, cull_en_nxt;

  vfc_pkg::mem_req_t            mem_req;
  logic [vfc_pkg::KIND_W-1:0]   mem_rdata;

  assign cfg_ready   = 1'b1;
  assign cull_en_nxt = (cfg_valid && cfg_ready) ? cfg_data : cull_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cull_en_r <= 1'b1;
    end else begin
      cull_en_r <= cull_en_nxt;
    end
  end

  // The sequencer owns the single store port: it sweeps zeros after reset,
  // takes voxel writes in the cycle they are accepted, and for a query reads the
  // voxel and then, for a solid voxel with culling on, its six neighbours on
  // consecutive cycles. Each item is finished before the next one is accepted,
  // so the store never sees a read and a write to the same entry in flight together.
  vfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .cull_en    (cull_en_r),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // Voxel types, one byte per cell, addressed x + SIDE * (z + SIDE * y).
  vfc_ram #(
    .WIDTH (vfc_pkg::KIND_W),
    .DEPTH (vfc_pkg::DEPTH)
  ) u_voxel_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

@@ test/tb_voxel_face_culler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_face_culler
// Self-checking bench: a behavioral voxel grid predicts the faces of every
// query, and each strobed result is compared with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_voxel_face_culler;

  import vfc_pkg::*;

  // Settle time after the last expected result. A write gives no result, so
  // one may still be in flight when the face queue runs dry.
  localparam int SETTLE_CYCLES = 16;
  // Upper bound on a single drain.
  localparam int DRAIN_LIMIT   = 1000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  vfc_in_t  in_item;
  logic     out_strobe;
  vfc_out_t out_item;
  logic     cfg_valid;
  logic     cfg_ready;
  logic     cfg_data;

  voxel_face_culler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Behavioral copy of the grid, indexed [x][y][z]. bit storage starts at
  // zero, which matches the all-air state after the clearing pass.
  bit [KIND_W-1:0] voxel_model [SIDE][HEIGHT][SIDE];
  bit              cull_on = 1'b1;

  // Faces predicted for accepted queries, oldest first.
  vfc_out_t pending_faces [$];

  int error_count = 0;
  int idle_pct    = 0;

  // Origin of the 4x4x4 box the random items are drawn from. Keeping items
  // in a small box makes neighbors collide often enough to exercise culling.
  int box_x, box_y, box_z;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: the timeout leaves a wide margin over the clearing pass and the
  // stimulus, and reports a failure and ends the run if it is reached.
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic note_error(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      note_error($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Texture layer per block type and face. Type 1 is the grass-like block with
  // a distinct top and bottom; types 2 and 3 swap layers; 4 to 9 map to
  // themselves; anything unlisted, and air, uses layer zero.
  function automatic logic [TEX_W-1:0] face_texture(input logic [KIND_W-1:0] kind,
                                                    input logic [FACE_W-1:0] face);
    case (kind)
      8'd1: begin
        if (face == FACE_TOP) return 4'd0;
        if (face == FACE_BOTTOM) return 4'd2;
        return 4'd1;
      end
      8'd2: return 4'd3;
      8'd3: return 4'd2;
      8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9: return kind[TEX_W-1:0];
      default: return 4'd0;
    endcase
  endfunction

  // Works out the results of one query against the current grid and queues
  // them. Neighbors beyond the grid boundary count as solid.
  function automatic void predict_faces(input vfc_in_t q);
    vfc_out_t          r;
    logic [FACE_W-1:0] fc;
    int                nx, ny, nz;
    int                shown;
    bit                visible;

    r               = '0;
    r.out_x         = q.pos_x;
    r.out_y         = q.pos_y;
    r.out_z         = q.pos_z;
    r.block_kind    = voxel_model[q.pos_x][q.pos_y][q.pos_z];
    shown           = 0;

    // An air voxel yields a single empty result.
    if (r.block_kind == '0) begin
      r.last = 1'b1;
      pending_faces.insert(pending_faces.size(), r);
      return;
    end

    for (int f = 0; f < NUM_FACES; f++) begin
      fc = FACE_W'(f);
      nx = q.pos_x;
      ny = q.pos_y;
      nz = q.pos_z;
      case (fc)
        FACE_FRONT:  nz++;
        FACE_RIGHT:  nx++;
        FACE_TOP:    ny++;
        FACE_LEFT:   nx--;
        FACE_BOTTOM: ny--;
        default:     nz--;
      endcase
      visible = 1'b1;
      if (cull_on) begin
        if (nx < 0 || nx >= SIDE || ny < 0 || ny >= HEIGHT || nz < 0 || nz >= SIDE) begin
          visible = 1'b0;
        end else begin
          visible = (voxel_model[nx][ny][nz] == '0);
        end
      end
      if (visible) begin
        r.face_valid    = 1'b1;
        r.face_id       = fc;
        r.texture_layer = face_texture(r.block_kind, fc);
        pending_faces.insert(pending_faces.size(), r);
        shown++;
      end
    end

    // A solid voxel with every face hidden still answers once, empty.
    if (shown == 0) begin
      r.face_valid    = 1'b0;
      r.face_id       = FACE_FRONT;
      r.texture_layer = '0;
      r.last          = 1'b1;
      pending_faces.insert(pending_faces.size(), r);
    end else begin
      pending_faces[pending_faces.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic vfc_in_t make_item(input logic req, input int x, input int y,
                                        input int z, input int kind);
    vfc_in_t it;
    it.req_type   = req;
    it.pos_x      = X_W'(x);
    it.pos_y      = Y_W'(y);
    it.pos_z      = Z_W'(z);
    it.write_type = KIND_W'(kind);
    return it;
  endfunction

  // Sender idling: with the phase's probability, drop start for a while so
  // that gaps land on every cycle of a query's read and emit sequence.
  task automatic idle_gap();
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  // Offers one item and holds it until the block takes it. The grid model is
  // updated at the accepting edge, so later queries see the write.
  task automatic send_item(input vfc_in_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    if (it.req_type == REQ_WRITE) begin
      voxel_model[it.pos_x][it.pos_y][it.pos_z] = it.write_type;
    end else begin
      predict_faces(it);
    end
    idle_gap();
  endtask

  // Lowers start and waits until every predicted face has come back and the
  // block is quiet. Faces still owed after the limit are failures.
  task automatic wait_idle();
    int waited;
    start  <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while ((pending_faces.size() != 0 || busy !== 1'b0) && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_faces.size() != 0) begin
      note_error($sformatf("%0d expected results never arrived", pending_faces.size()));
      pending_faces.delete();
    end
  endtask

  // Register write; only called with the block drained.
  task automatic write_cull(input bit value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cull_on = value;
    cfg_valid <= 1'b0;
  endtask

  // Result checker. Results cannot be held off, so every strobe is consumed
  // at the edge that ends its cycle and matched against the oldest face.
  always @(posedge clk) begin : result_checker
    vfc_out_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_faces.size() == 0) begin
        note_error($sformatf("unexpected result at (%0d,%0d,%0d)",
                             out_item.out_x, out_item.out_y, out_item.out_z));
      end else begin
        want = pending_faces.pop_front();
        check_field("face_valid", out_item.face_valid, want.face_valid);
        check_field("face_id", out_item.face_id, want.face_id);
        check_field("out_x", out_item.out_x, want.out_x);
        check_field("out_y", out_item.out_y, want.out_y);
        check_field("out_z", out_item.out_z, want.out_z);
        check_field("block_kind", out_item.block_kind, want.block_kind);
        check_field("texture_layer", out_item.texture_layer, want.texture_layer);
        check_field("last", out_item.last, want.last);
      end
    end
  end

  // Queries of untouched voxels at both grid corners give the air result.
  task automatic test_air_queries();
    send_item(make_item(REQ_QUERY, 0, 0, 0, 0));
    send_item(make_item(REQ_QUERY, SIDE - 1, HEIGHT - 1, SIDE - 1, 255));
    wait_idle();
  endtask

  // A lone grass block in open air shows all six faces with its own layers.
  task automatic test_lone_voxel();
    send_item(make_item(REQ_WRITE, 5, 5, 5, 1));
    send_item(make_item(REQ_QUERY, 5, 5, 5, 0));
    wait_idle();
  endtask

  // Surrounding the block on all sides hides every face, leaving the empty
  // result that still names the block type. A neighbor then loses one face.
  task automatic test_buried_voxel();
    send_item(make_item(REQ_WRITE, 5, 5, 6, 2));
    send_item(make_item(REQ_WRITE, 6, 5, 5, 3));
    send_item(make_item(REQ_WRITE, 5, 6, 5, 4));
    send_item(make_item(REQ_WRITE, 4, 5, 5, 5));
    send_item(make_item(REQ_WRITE, 5, 4, 5, 6));
    send_item(make_item(REQ_WRITE, 5, 5, 4, 7));
    send_item(make_item(REQ_QUERY, 5, 5, 5, 0));
    send_item(make_item(REQ_QUERY, 5, 5, 6, 0));
    wait_idle();
  endtask

  // Two grid corners and an inner cell: the out-of-grid neighbors count as solid. Types 255
  // and 10 are unlisted and use layer zero; type 9 is the last listed one.
  task automatic test_grid_edges();
    send_item(make_item(REQ_WRITE, 0, 0, 0, 255));
    send_item(make_item(REQ_QUERY, 0, 0, 0, 0));
    send_item(make_item(REQ_WRITE, SIDE - 1, HEIGHT - 1, SIDE - 1, 9));
    send_item(make_item(REQ_QUERY, SIDE - 1, HEIGHT - 1, SIDE - 1, 0));
    send_item(make_item(REQ_WRITE, 20, 40, 20, 10));
    send_item(make_item(REQ_QUERY, 20, 40, 20, 0));
    wait_idle();
  endtask

  // With culling off a buried or cornered block shows all six faces. Writing
  // air back over a block turns its query into the air result.
  task automatic test_culling_off();
    write_cull(1'b0);
    send_item(make_item(REQ_QUERY, 5, 5, 5, 0));
    send_item(make_item(REQ_QUERY, 0, 0, 0, 0));
    send_item(make_item(REQ_WRITE, 5, 5, 5, 0));
    send_item(make_item(REQ_QUERY, 5, 5, 5, 0));
    wait_idle();
    write_cull(1'b1);
  endtask

  // Box origins favor the grid edges so boundary culling is hit often.
  function automatic int pick_origin(input int span);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return span - 4;
      default: return $urandom_range(0, span - 4);
    endcase
  endfunction

  // Mostly writes and queries inside the current box, with some writes of
  // air so faces come and go; one item in ten lands anywhere in the grid.
  function automatic vfc_in_t random_item();
    int   x, y, z, kind;
    logic req;
    x = box_x + $urandom_range(0, 3);
    y = box_y + $urandom_range(0, 3);
    z = box_z + $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      x = $urandom_range(0, SIDE - 1);
      y = $urandom_range(0, HEIGHT - 1);
      z = $urandom_range(0, SIDE - 1);
    end
    req = ($urandom_range(0, 99) < 45) ? REQ_QUERY : REQ_WRITE;
    case ($urandom_range(0, 9))
      0, 1, 2: kind = 0;
      9:       kind = $urandom_range(0, 255);
      default: kind = $urandom_range(1, 12);
    endcase
    // The type field is unused on a query; drive it anyway so its bits move.
    if (req == REQ_QUERY) begin
      kind = $urandom_range(0, 255);
    end
    return make_item(req, x, y, z, kind);
  endfunction

  // One random phase under a given culling setting and sender idle rate.
  task automatic test_random_phase(input int idle, input bit cull, input int count);
    write_cull(cull);
    idle_pct = idle;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        box_x = pick_origin(SIDE);
        box_y = pick_origin(HEIGHT);
        box_z = pick_origin(SIDE);
      end
      send_item(random_item());
    end
    wait_idle();
    idle_pct = 0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The first item waits out the clearing pass through the busy handshake.
    test_air_queries();
    test_lone_voxel();
    test_buried_voxel();
    test_grid_edges();
    test_culling_off();

    test_random_phase(0, 1'b1, 97);
    test_random_phase(65, 1'b0, 97);
    test_random_phase(22, 1'b1, 97);
    test_random_phase(65, 1'b1, 97);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/vfc_pkg.sv
hw/rtl/vfc_ram.sv
hw/rtl/vfc_ctrl.sv
hw/rtl/voxel_face_culler.sv
test/tb_voxel_face_culler.sv
